[rtl/prc_pkg.sv]
// Shared constants and types for the reserved frame carver.
package prc_pkg;

  localparam int FRAME_BITS   = 40;
  localparam int LIMIT_BITS   = FRAME_BITS + 1;
  localparam int INDEX_BITS   = 5;
  localparam int COUNT_BITS   = 6;
  localparam int DEPTH_DEF    = 32;

  localparam int S_DATA_BITS  = 128;
  localparam int M_FIELD_BITS = FRAME_BITS + LIMIT_BITS;
  localparam int M_DATA_BITS  = ((M_FIELD_BITS + 7) / 8) * 8;
  localparam int M_PAD_BITS   = M_DATA_BITS - M_FIELD_BITS;

  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;

  // register index of the table count
  localparam logic REG_COUNT = 1'b0;

  // request kinds carried on s_tuser
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_CARVE = 1'b1;

  typedef struct packed {
    logic [LIMIT_BITS-1:0] base;
    logic [LIMIT_BITS-1:0] limit;
  } piece_t;

endpackage

[rtl/pfn_range_reserved_carver_core.sv]
// Reserved frame carver: cuts reserved frames out of physical ranges.
// A load request returns nothing.
// A carve request occupies the block from accept through a scan of min(reserved_count, RESERVED_DEPTH) table
// entries (one table read per entry), tail and final flush, and is held longer while the output stalls.
// The first piece is held back and offered on the output only once a later piece pushes it out or the carve flushes.
// Reset (rst, synchronous) clears control and the count register; table contents persist.
module pfn_range_reserved_carver_core #(
  parameter int RESERVED_DEPTH = prc_pkg::DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // s_tdata: entry_index[4:0], entry_pfn[44:5], range_base[84:45], range_limit[125:85]
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [prc_pkg::S_DATA_BITS-1:0]  s_tdata,
  // s_tuser: cmd
  input  logic                             s_tuser,
  // m_tdata: piece_base[39:0], piece_limit[80:40]
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [prc_pkg::M_DATA_BITS-1:0]  m_tdata,
  // m_tuser: piece_valid
  output logic                             m_tuser,
  output logic                             m_tlast,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [prc_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [prc_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [prc_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                             pready
);
  import prc_pkg::*;

  localparam int AW = (RESERVED_DEPTH > 1) ? $clog2(RESERVED_DEPTH) : 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_TAIL  = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  logic [FRAME_BITS-1:0] table_mem [RESERVED_DEPTH];
  logic [FRAME_BITS-1:0] rdata;

  logic [1:0]            state;
  logic [COUNT_BITS-1:0] reserved_count;
  logic [COUNT_BITS-1:0] scan_count;
  logic [COUNT_BITS-1:0] pos;
  logic [COUNT_BITS-1:0] raddr;
  logic [LIMIT_BITS-1:0] cursor;
  logic [LIMIT_BITS-1:0] active_limit;
  piece_t                pend;
  logic                  pend_valid;
  logic [FRAME_BITS-1:0] out_base;
  logic [LIMIT_BITS-1:0] out_limit;

  logic [INDEX_BITS-1:0] in_index;
  logic [FRAME_BITS-1:0] in_pfn;
  logic [FRAME_BITS-1:0] in_base;
  logic [LIMIT_BITS-1:0] in_limit;
  logic [LIMIT_BITS-1:0] sat_limit;
  logic [COUNT_BITS-1:0] count_eff;

  logic                  in_fire;
  logic                  out_free;
  logic                  out_load;
  logic [LIMIT_BITS-1:0] entry;
  logic                  hit;
  piece_t                cand;
  logic                  cand_valid;
  logic                  stall;
  logic                  scan_done;
  logic                  cfg_write;

  assign in_index = s_tdata[INDEX_BITS-1:0];
  assign in_pfn   = s_tdata[INDEX_BITS +: FRAME_BITS];
  assign in_base  = s_tdata[INDEX_BITS+FRAME_BITS +: FRAME_BITS];
  assign in_limit = s_tdata[INDEX_BITS+2*FRAME_BITS +: LIMIT_BITS];

  // clamp the limit to the top of frame space
  assign sat_limit = in_limit[FRAME_BITS] ? {1'b1, {FRAME_BITS{1'b0}}} : in_limit;
  assign count_eff = (reserved_count > COUNT_BITS'(RESERVED_DEPTH)) ?
                     COUNT_BITS'(RESERVED_DEPTH) : reserved_count;

  assign s_tready = (state == ST_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign entry = {1'b0, rdata};
  assign hit   = (entry >= cursor) && (entry < active_limit);

  always_comb begin
    cand       = '{base: cursor, limit: active_limit};
    cand_valid = 1'b0;
    case (state)
      ST_SCAN: begin
        cand.limit = entry;
        cand_valid = hit && (entry != cursor);
      end
      ST_TAIL: begin
        cand_valid = (cursor < active_limit);
      end
      default: begin
        cand_valid = 1'b0;
      end
    endcase
  end

  // a new piece pushes the held one out, so the output must have room
  assign stall     = cand_valid && pend_valid && !out_free;
  assign scan_done = ((pos + COUNT_BITS'(1)) == scan_count);

  // load the output register when a held piece is released or the carve closes
  assign out_load  = (cand_valid && !stall && pend_valid) ||
                     ((state == ST_FLUSH) && out_free);

  always_comb begin
    raddr = pos;
    if (state == ST_IDLE) begin
      raddr = '0;
    end else if ((state == ST_SCAN) && !stall) begin
      raddr = pos + COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (s_tuser == CMD_LOAD) &&
        ({1'b0, in_index} < COUNT_BITS'(RESERVED_DEPTH))) begin
      table_mem[AW'(in_index)] <= in_pfn;
    end
    rdata <= table_mem[raddr[AW-1:0]];
  end

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_COUNT) ?
                     {{(APB_DATA_BITS-COUNT_BITS){1'b0}}, reserved_count} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      reserved_count <= '0;
    end else if (cfg_write && (paddr[2] == REG_COUNT)) begin
      reserved_count <= pwdata[COUNT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pos        <= '0;
      scan_count <= '0;
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
      cursor     <= '0;
      active_limit <= '0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      // hold the newest piece, release the previous one as not last
      if (cand_valid && !stall) begin
        if (pend_valid) begin
          out_base  <= pend.base[FRAME_BITS-1:0];
          out_limit <= pend.limit;
          m_tuser   <= 1'b1;
          m_tlast   <= 1'b0;
        end
        pend       <= cand;
        pend_valid <= 1'b1;
      end

      case (state)
        ST_IDLE: begin
          if (in_fire && (s_tuser == CMD_CARVE)) begin
            cursor       <= {1'b0, in_base};
            active_limit <= sat_limit;
            scan_count   <= count_eff;
            pos          <= '0;
            state        <= (count_eff == '0) ? ST_TAIL : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (!stall) begin
            if (hit) begin
              cursor <= entry + LIMIT_BITS'(1);
            end
            if (scan_done) begin
              state <= ST_TAIL;
            end else begin
              pos <= pos + COUNT_BITS'(1);
            end
          end
        end
        ST_TAIL: begin
          if (!stall) begin
            state <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          if (out_free) begin
            m_tlast  <= 1'b1;
            m_tuser  <= pend_valid;
            if (pend_valid) begin
              out_base  <= pend.base[FRAME_BITS-1:0];
              out_limit <= pend.limit;
            end else begin
              out_base  <= '0;
              out_limit <= '0;
            end
            pend_valid   <= 1'b0;
            cursor       <= '0;
            active_limit <= '0;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {{M_PAD_BITS{1'b0}}, out_limit, out_base};

endmodule

[rtl/prc_checker.sv]
// Port-level checks for the reserved frame carver, bound to the carver core module.
module prc_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [prc_pkg::M_DATA_BITS-1:0]   m_tdata,
  input logic                              m_tuser,
  input logic                              m_tlast
);
  import prc_pkg::*;

  logic [LIMIT_BITS-1:0] obs_base;
  logic [LIMIT_BITS-1:0] obs_limit;

  assign obs_base  = {1'b0, m_tdata[FRAME_BITS-1:0]};
  assign obs_limit = m_tdata[FRAME_BITS +: LIMIT_BITS];

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("stalled result changed");

  // an empty answer closes its carve and carries no frames
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tlast && (m_tdata == '0))
    else $error("empty answer malformed");

  // every usable piece is non-empty
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> obs_base < obs_limit)
    else $error("empty piece emitted");

  // pieces of one carve come in ascending order
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tuser && !m_tlast ##1 m_tvalid && m_tuser
      |-> obs_base > $past(obs_limit) || obs_base == $past(obs_limit)
        || $past(m_tdata) == m_tdata)
    else $error("pieces out of order");

endmodule

bind pfn_range_reserved_carver_core prc_checker u_prc_checker (.*);
